// ===== rtl/core/ped_pkg.sv =====
// shared types, constants and helpers for the pheromone evaporate/deposit block
`default_nettype none

package ped_pkg;

  // default sizing of the pheromone store
  localparam int unsigned DEF_MAX_MATRICES = 4;
  localparam int unsigned DEF_MAX_VERTICES = 256;

  // register reset values
  localparam logic [15:0] RESET_RATE  = 16'd6554;
  localparam logic [31:0] RESET_FLOOR = 32'd655;

  // configuration register indexes
  localparam logic REG_EVAP_RATE = 1'b0;
  localparam logic REG_FLOOR     = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_LOOKUP,
    ST_UPDATE
  } ped_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear_wr;   // write reset floor at the sweep counter
    logic sweep_rd;   // read the next entry of the evaporation sweep
    logic load_item;  // capture the accepted transaction
    logic dep_rd;     // read the addressed entry
    logic dep_wr;     // write the deposited entry and load the output register
  } ped_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cnt_last;   // sweep counter at the last entry
    logic pipe_busy;  // evaporation pipeline still holds entries
    logic out_free;   // output register can take a new result this cycle
  } ped_status_t;

  // remainder of a narrow value by a constant modulus, restoring compare-subtract
  function automatic logic [7:0] mod_narrow(input logic [7:0] v, input int unsigned m);
    logic [19:0] r;
    logic [19:0] d;
    r = {12'd0, v};
    for (int i = 7; i >= 0; i--) begin
      d = 20'(m) << i;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pheromone_evaporate_deposit.sv =====
// top level of the max-min pheromone store: evaporation sweep and per-pair deposit
//
// Holds MAX_MATRICES pheromone matrices of MAX_VERTICES x MAX_VERTICES Q16.16 entries in
// one simple dual-port memory (one write and one registered read per cycle). After reset
// the block runs a clearing pass that writes the floor value 655 into every entry, one
// entry per cycle; during the pass in_stall is high while configuration writes are still
// taken. A deposit is a read-modify-write of one entry (read, then add/cap/write); the
// result sits in an output register so the next transaction is taken while it waits.
// A transaction with start_of_update set first sweeps the whole store through a
// three-stage read/scale/write pipeline, one entry per cycle, before its deposit.
`default_nettype none

module pheromone_evaporate_deposit
  import ped_pkg::*;
#(
  parameter int unsigned MAX_MATRICES = DEF_MAX_MATRICES,
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        start_of_update,
  input  wire logic [1:0]  network_index,
  input  wire logic [7:0]  row_node,
  input  wire logic [7:0]  col_node,
  input  wire logic [15:0] current_quality,
  input  wire logic [15:0] quality_cap,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      updated_level
);

  ped_cmd_t    cmd;
  ped_status_t status;

  // sequencing
  ped_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .start_of_update (start_of_update),
    .status          (status),
    .cmd             (cmd),
    .in_stall        (in_stall)
  );

  // storage and arithmetic
  ped_datapath #(
    .MAX_MATRICES (MAX_MATRICES),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .network_index   (network_index),
    .row_node        (row_node),
    .col_node        (col_node),
    .current_quality (current_quality),
    .quality_cap     (quality_cap),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .updated_level   (updated_level)
  );

  // deposit read only once the evaporation pipeline has written everything back
  a_lookup_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.dep_rd |-> !status.pipe_busy)
    else $error("deposit read while evaporation pipeline busy");

  // a result is never loaded over one that is still waiting
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.dep_wr |-> status.out_free)
    else $error("output register overwritten");

  // memory commands are mutually exclusive
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_wr, cmd.sweep_rd, cmd.dep_rd, cmd.dep_wr}))
    else $error("conflicting memory commands");

  // no transaction taken during the clearing pass or the sweep
  a_stall_while_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.clear_wr || cmd.sweep_rd || status.pipe_busy) |-> in_stall)
    else $error("input taken while store busy");

endmodule

`default_nettype wire

// ===== rtl/core/ped_ctrl.sv =====
// controller state machine: clearing pass, evaporation sweep and deposit sequencing
`default_nettype none

module ped_ctrl
  import ped_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        start_of_update,
  input  wire ped_status_t status,
  output ped_cmd_t         cmd,
  output logic             in_stall
);

  ped_state_t state;
  ped_state_t state_next;
  logic       take;

  // input transaction can be taken when idle or while finishing a deposit
  always_comb begin
    take = 1'b0;
    case (state)
      ST_IDLE:   take = 1'b1;
      ST_UPDATE: take = status.out_free;
      default:   take = 1'b0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = start_of_update ? ST_SWEEP : ST_LOOKUP;
      end
      ST_SWEEP: begin
        if (status.cnt_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status.out_free) begin
          if (in_valid) begin
            state_next = start_of_update ? ST_SWEEP : ST_LOOKUP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    in_stall      = !take;
    cmd.load_item = take && in_valid;
    case (state)
      ST_CLEAR:  cmd.clear_wr = 1'b1;
      ST_SWEEP:  cmd.sweep_rd = 1'b1;
      ST_LOOKUP: cmd.dep_rd   = 1'b1;
      ST_UPDATE: cmd.dep_wr   = status.out_free;
      default:   cmd.clear_wr = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ped_datapath.sv =====
// datapath: pheromone memory, sweep counter, evaporation pipeline, deposit and output register
`default_nettype none

module ped_datapath
  import ped_pkg::*;
#(
  parameter int unsigned MAX_MATRICES = DEF_MAX_MATRICES,
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ped_cmd_t    cmd,
  output ped_status_t      status,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [1:0]  network_index,
  input  wire logic [7:0]  row_node,
  input  wire logic [7:0]  col_node,
  input  wire logic [15:0] current_quality,
  input  wire logic [15:0] quality_cap,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      updated_level
);

  localparam int unsigned DEPTH  = MAX_MATRICES * MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rdata;
  logic [15:0]       evaporation_rate;
  logic [31:0]       pheromone_floor;
  logic [ADDR_W-1:0] sweep_addr;
  logic [ADDR_W-1:0] dep_addr;
  logic [15:0]       cur_q;
  logic [15:0]       best_q;
  logic              s1_v;
  logic              s2_v;
  logic [ADDR_W-1:0] s1_addr;
  logic [ADDR_W-1:0] s2_addr;
  logic [48:0]       prod;
  logic [16:0]       keep;
  logic [31:0]       evap_level;
  logic [32:0]       dep_sum;
  logic [31:0]       dep_sat;
  logic [31:0]       dep_cap;
  logic [31:0]       dep_level;
  logic [1:0]        net_m;
  logic [7:0]        row_m;
  logic [7:0]        col_m;
  logic [31:0]       addr_full;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      evaporation_rate <= RESET_RATE;
      pheromone_floor  <= RESET_FLOOR;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EVAP_RATE: evaporation_rate <= cfg_data[15:0];
        REG_FLOOR:     pheromone_floor  <= cfg_data;
        default:       pheromone_floor  <= pheromone_floor;
      endcase
    end
  end

  // entry address of the incoming transaction, indices wrapped to the store size
  always_comb begin
    net_m     = 2'(mod_narrow({6'd0, network_index}, MAX_MATRICES));
    row_m     = mod_narrow(row_node, MAX_VERTICES);
    col_m     = mod_narrow(col_node, MAX_VERTICES);
    addr_full = (32'(net_m) * 32'(MAX_VERTICES) + 32'(row_m)) * 32'(MAX_VERTICES)
                + 32'(col_m);
  end

  // captured transaction
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      dep_addr <= addr_full[ADDR_W-1:0];
      cur_q    <= current_quality;
      best_q   <= quality_cap;
    end
  end

  // sweep counter shared by the clearing pass and the evaporation sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.clear_wr || cmd.sweep_rd) begin
      sweep_addr <= (sweep_addr == LAST_ADDR) ? '0 : sweep_addr + 1'b1;
    end
  end

  // evaporation pipeline: read, scale, floor and write back
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= cmd.sweep_rd;
      s2_v <= s1_v;
    end
  end

  assign keep = 17'h10000 - {1'b0, evaporation_rate};

  always_ff @(posedge clk) begin
    s1_addr <= sweep_addr;
    s2_addr <= s1_addr;
    prod    <= 49'(rdata) * 49'(keep);
  end

  assign evap_level = (prod[47:16] < pheromone_floor) ? pheromone_floor : prod[47:16];

  // deposit: saturating add then cap at the best quality
  always_comb begin
    dep_sum   = {1'b0, rdata} + {1'b0, cur_q, 16'd0};
    dep_sat   = dep_sum[32] ? 32'hFFFF_FFFF : dep_sum[31:0];
    dep_cap   = {best_q, 16'd0};
    dep_level = (dep_sat > dep_cap) ? dep_cap : dep_sat;
  end

  // memory port selection
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = dep_addr;
    wr_data = dep_level;
    if (cmd.clear_wr) begin
      wr_addr = sweep_addr;
      wr_data = RESET_FLOOR;
    end else if (s2_v) begin
      wr_addr = s2_addr;
      wr_data = evap_level;
    end else if (!cmd.dep_wr) begin
      wr_en   = 1'b0;
    end
    rd_en   = cmd.sweep_rd || cmd.dep_rd;
    rd_addr = cmd.sweep_rd ? sweep_addr : dep_addr;
  end

  // pheromone store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.dep_wr) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dep_wr) begin
      updated_level <= dep_level;
    end
  end

  // status back to the controller
  always_comb begin
    status.cnt_last  = (sweep_addr == LAST_ADDR);
    status.pipe_busy = s1_v || s2_v;
    status.out_free  = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for the pheromone evaporate/deposit block: directed table, random phases, predictor
`default_nettype none

module tb_top;
  import ped_pkg::*;

  localparam int unsigned TABLE_DEPTH = DEF_MAX_MATRICES * DEF_MAX_VERTICES * DEF_MAX_VERTICES;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned PRINT_LIMIT = 40;

  // one deposit transaction as offered on the input channel
  typedef struct {
    logic        start;
    logic [1:0]  net;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] cur;
    logic [15:0] best;
  } deposit_t;

  // directed row: transaction plus an optional hand-typed level
  typedef struct {
    deposit_t    item;
    bit          typed;
    logic [31:0] level;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        start_of_update = 1'b0;
  logic [1:0]  network_index = 2'd0;
  logic [7:0]  row_node = 8'd0;
  logic [7:0]  col_node = 8'd0;
  logic [15:0] current_quality = 16'd0;
  logic [15:0] quality_cap = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] updated_level;

  // predictor state
  bit   [31:0] level_store [TABLE_DEPTH];
  logic [15:0] model_rate;
  logic [31:0] model_floor;
  logic [31:0] expected_levels [$];
  directed_row_t directed_rows [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  bit          hold_request = 1'b0;

  pheromone_evaporate_deposit dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .start_of_update (start_of_update),
    .network_index   (network_index),
    .row_node        (row_node),
    .col_node        (col_node),
    .current_quality (current_quality),
    .quality_cap     (quality_cap),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .updated_level   (updated_level)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch %s: got %h want %h", what, got, want);
    mismatch_count++;
  endtask

  // scale every entry by the retained factor, truncate, raise to floor
  function automatic void evaporate_levels();
    logic [16:0] keep;
    logic [63:0] scaled;
    keep = 17'h10000 - {1'b0, model_rate};
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      scaled = ({32'd0, level_store[i]} * {47'd0, keep}) >> 16;
      if (scaled < {32'd0, model_floor})
        scaled = {32'd0, model_floor};
      level_store[i] = scaled[31:0];
    end
  endfunction

  // new level of the addressed entry: saturating add, then cap at best
  function automatic logic [31:0] predict_deposit(input deposit_t it);
    int unsigned addr;
    logic [32:0] sum;
    if (it.start)
      evaporate_levels();
    addr = ((it.net % DEF_MAX_MATRICES) * DEF_MAX_VERTICES + (it.row % DEF_MAX_VERTICES))
           * DEF_MAX_VERTICES + (it.col % DEF_MAX_VERTICES);
    sum = {1'b0, level_store[addr]} + {1'b0, it.cur, 16'd0};
    if (sum > 33'h0FFFFFFFF)
      sum = 33'h0FFFFFFFF;
    if (sum > {1'b0, it.best, 16'd0})
      sum = {1'b0, it.best, 16'd0};
    level_store[addr] = sum[31:0];
    return sum[31:0];
  endfunction

  function automatic void add_row(input logic start, input logic [1:0] net,
                                  input logic [7:0] row, input logic [7:0] col,
                                  input logic [15:0] cur, input logic [15:0] best,
                                  input bit typed, input logic [31:0] level);
    directed_row_t r;
    r.item = '{start, net, row, col, cur, best};
    r.typed = typed;
    r.level = level;
    directed_rows.push_back(r);
  endfunction

  // mostly a small set of hot entries so deposits pile up and hit the cap
  function automatic deposit_t random_item();
    deposit_t it;
    it.start = 1'b0;
    it.net = 2'($urandom_range(3));
    if ($urandom_range(99) < 70) begin
      it.row = 8'($urandom_range(3) * 85);
      it.col = 8'($urandom_range(3) * 85);
    end else begin
      it.row = 8'($urandom_range(255));
      it.col = 8'($urandom_range(255));
    end
    it.cur = ($urandom_range(1) == 0) ? 16'($urandom_range(15)) : 16'($urandom_range(65535));
    case ($urandom_range(4))
      0: it.best = 16'hFFFF;
      1: it.best = 16'($urandom_range(15));
      default: it.best = 16'($urandom_range(65535));
    endcase
    return it;
  endfunction

  // register write; the caller lowers cfg_write after the last one
  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == REG_EVAP_RATE)
      model_rate = data[15:0];
    else if (idx == REG_FLOOR)
      model_floor = data;
  endtask

  // offer one transaction, predict its level once accepted
  task automatic offer_item(input deposit_t it, input bit typed, input logic [31:0] level);
    logic [31:0] predicted;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    start_of_update <= it.start;
    network_index <= it.net;
    row_node <= it.row;
    col_node <= it.col;
    current_quality <= it.cur;
    quality_cap <= it.best;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    predicted = predict_deposit(it);
    expected_levels.push_back(typed ? level : predicted);
  endtask

  task automatic wait_drained();
    while (expected_levels.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] rate, input logic [31:0] floor_val,
                           input bit with_sweep, input int unsigned spct,
                           input int unsigned rpct, input int unsigned n,
                           input bit pressure);
    int unsigned sweep_at;
    deposit_t it;
    write_reg(REG_EVAP_RATE, {16'd0, rate});
    write_reg(REG_FLOOR, floor_val);
    cfg_write <= 1'b0;
    send_pct = spct;
    recv_pct = rpct;
    if (pressure)
      hold_request = 1'b1;
    sweep_at = $urandom_range(n - 10, 10);
    for (int unsigned i = 0; i < n; i++) begin
      it = random_item();
      it.start = with_sweep && (i == sweep_at);
      offer_item(it, 1'b0, 32'd0);
    end
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        report_mismatch("result with no transaction pending", updated_level, 'x);
      end else begin
        want = expected_levels.pop_front();
        if (updated_level !== want)
          report_mismatch("updated_level", updated_level, want);
      end
    end
  end

  // main sequence
  initial begin
    model_rate = RESET_RATE;
    model_floor = RESET_FLOOR;
    for (int unsigned i = 0; i < TABLE_DEPTH; i++)
      level_store[i] = RESET_FLOOR;

    // directed rows under reset configuration; store holds the reset floor
    add_row(1'b0, 2'd0, 8'h00, 8'h00, 16'h0000, 16'hFFFF, 1'b1, 32'd655);
    add_row(1'b0, 2'd3, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF0000);
    // saturating sum, then capped
    add_row(1'b0, 2'd3, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF0000);
    // cap below floor
    add_row(1'b0, 2'd1, 8'h55, 8'hAA, 16'h0001, 16'h0000, 1'b1, 32'h00000000);
    add_row(1'b0, 2'd2, 8'hAA, 8'h55, 16'h0000, 16'h0000, 1'b1, 32'h00000000);
    add_row(1'b0, 2'd0, 8'h01, 8'h02, 16'h0003, 16'h0002, 1'b1, 32'h00020000);
    add_row(1'b0, 2'd1, 8'h01, 8'h01, 16'h8000, 16'hFFFF, 1'b1, 32'h8000028F);
    add_row(1'b0, 2'd0, 8'h00, 8'h00, 16'h7FFF, 16'h7FFF, 1'b1, 32'h7FFF0000);
    // evaporation sweep with reset rate and floor
    add_row(1'b1, 2'd0, 8'h00, 8'h00, 16'h0000, 16'hFFFF, 1'b0, 32'd0);
    add_row(1'b0, 2'd3, 8'hFF, 8'hFF, 16'h0000, 16'hFFFF, 1'b0, 32'd0);
    // zero entry raised back to floor
    add_row(1'b0, 2'd1, 8'h55, 8'hAA, 16'h0000, 16'hFFFF, 1'b1, 32'd655);
    add_row(1'b0, 2'd1, 8'h01, 8'h01, 16'h0000, 16'hFFFF, 1'b0, 32'd0);
    // untouched entry decays below floor, raised, then capped
    add_row(1'b0, 2'd2, 8'hFF, 8'h00, 16'h0001, 16'h0001, 1'b1, 32'h00010000);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].level);
    in_valid <= 1'b0;
    wait_drained();

    // floor raised without a sweep: store keeps old values; long receiver hold-off
    run_phase(16'd0, 32'hFFFFFFFF, 1'b0, 0, 0, 140, 1'b1);
    // zero rate, max floor sweep: every entry goes to the maximum
    run_phase(16'd0, 32'hFFFFFFFF, 1'b1, 56, 0, 140, 1'b0);
    // max rate, zero floor sweep: entries shrink to their upper half
    run_phase(16'hFFFF, 32'd0, 1'b1, 0, 56, 140, 1'b0);
    run_phase(16'($urandom_range(65534, 1)), $urandom, 1'b0, 17, 17, 130, 1'b0);

    repeat (20) @(posedge clk);
    if (expected_levels.size() != 0)
      report_mismatch("results never returned", 32'(expected_levels.size()), 32'd0);

    if (mismatch_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire
